// ===== rtl/siq_pkg.sv =====
package siq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int DATA_W    = 32;
    localparam int REQ_W     = 5;
    localparam int CNT_OUT_W = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic {
        A_INSERT = 1'b0,
        A_RESIZE = 1'b1
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_WRITE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
        logic clear;
    } t_cell_ctl;

endpackage

// ===== rtl/siq_cell.sv =====
module siq_cell (
    input  logic                                i_clk,
    input  siq_pkg::t_cell_ctl                  i_ctl,
    input  logic signed [siq_pkg::DATA_W-1:0]   i_left,
    input  logic signed [siq_pkg::DATA_W-1:0]   i_value,
    output logic signed [siq_pkg::DATA_W-1:0]   o_data,
    output logic                                o_lt,
    output logic                                o_eq
);
    import siq_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.load) begin
            n_data = i_value;
        end else if (i_ctl.shift) begin
            n_data = i_left;
        end else if (i_ctl.clear) begin
            n_data = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_lt   = (r_data < i_value);
    assign o_eq   = (r_data == i_value);

endmodule

// ===== rtl/sorted_insert_min_queue.sv =====
// Sorted insert minimum queue: up to DEPTH signed 32-bit entries kept in a row of cells.
// Slave stream: tdata = value[31:0], requested_count[36:32]; tuser = action
// (0 insert, 1 resize). Master stream: tdata = smallest[31:0], count[36:32];
// tuser = rejected. Every request gives exactly one result.
// An insert searches the cells in binary order, one probe per cycle against
// compare flags that every cell produces in parallel, then shifts the upper
// cells by one and loads the new value in the write state. An insert's time from
// acceptance to result valid depends on the probe count of the search.
// A resize skips the search; a rejection goes to done. One request is in flight at a
// time; the next is accepted in the cycle after the result moves to the output register.
// The output register holds the result while the receiver stalls; a new
// request may still be accepted and worked on, and its result waits in the
// done state until the register frees up.
// Reset (synchronous, active low) empties the queue; entry data is not cleared.
module sorted_insert_min_queue #(
    parameter int DEPTH = siq_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [siq_pkg::S_TDATA_W-1:0]   i_s_tdata,  // value, requested_count
    input  logic                            i_s_tuser,  // action
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [siq_pkg::M_TDATA_W-1:0]   o_m_tdata,  // smallest, count
    output logic                            o_m_tuser   // rejected
);
    import siq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = $clog2(DEPTH);
    localparam int CMPW = CW + REQ_W;
    localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

    t_state                   r_state, n_state;
    t_action                  r_action, n_action;
    logic signed [DATA_W-1:0] r_value, n_value;
    logic [REQ_W-1:0]         r_req, n_req;
    logic [CW-1:0]            r_lo, n_lo;
    logic [CW-1:0]            r_hip1, n_hip1;
    logic [IW-1:0]            r_pos, n_pos;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_rej, n_rej;
    logic                     r_out_valid, n_out_valid;
    logic [M_TDATA_W-1:0]     r_out_data, n_out_data;
    logic                     r_out_rej, n_out_rej;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         lt_vec;
    logic [DEPTH-1:0]         eq_vec;
    t_cell_ctl                cell_ctl [DEPTH];

    logic [CW:0]              mid_sum;
    logic [IW-1:0]            mid;
    logic signed [DATA_W-1:0] smallest;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic signed [DATA_W-1:0] left;
            if (gi == 0) begin : g_first
                assign left = r_value;
            end else begin : g_rest
                assign left = cell_data[gi-1];
            end

            always_comb begin
                cell_ctl[gi] = '0;
                if (r_state == S_WRITE) begin
                    if (r_action == A_INSERT) begin
                        cell_ctl[gi].load  = (IW'(gi) == r_pos);
                        cell_ctl[gi].shift = (IW'(gi) > r_pos) && (CW'(gi) <= r_count);
                    end else begin
                        cell_ctl[gi].clear = (CMPW'(gi) >= CMPW'(r_count)) &&
                                             (CMPW'(gi) < CMPW'(r_req));
                    end
                end
            end

            siq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[gi]),
                .i_left  (left),
                .i_value (r_value),
                .o_data  (cell_data[gi]),
                .o_lt    (lt_vec[gi]),
                .o_eq    (eq_vec[gi])
            );
        end
    endgenerate

    assign mid_sum  = (CW+1)'(r_lo) + (CW+1)'(r_hip1) - (CW+1)'(1);
    assign mid      = mid_sum[IW:1];
    assign smallest = (r_count == '0) ? -32'sd1 : cell_data[0];

    always_comb begin
        n_state     = r_state;
        n_action    = r_action;
        n_value     = r_value;
        n_req       = r_req;
        n_lo        = r_lo;
        n_hip1      = r_hip1;
        n_pos       = r_pos;
        n_count     = r_count;
        n_rej       = r_rej;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        n_out_rej   = r_out_rej;
        o_s_tready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_action = t_action'(i_s_tuser);
                    n_value  = i_s_tdata[DATA_W-1:0];
                    n_req    = i_s_tdata[DATA_W +: REQ_W];
                    n_lo     = '0;
                    n_hip1   = r_count;
                    n_rej    = 1'b0;
                    if (t_action'(i_s_tuser) == A_INSERT) begin
                        if (CMPW'(r_count) >= DEPTH_C) begin
                            n_rej   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SEARCH;
                        end
                    end else begin
                        if (CMPW'(i_s_tdata[DATA_W +: REQ_W]) > DEPTH_C) begin
                            n_rej   = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_WRITE;
                        end
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hip1) begin
                    if (eq_vec[mid]) begin
                        n_pos   = mid;
                        n_state = S_WRITE;
                    end else if (lt_vec[mid]) begin
                        n_lo = CW'(mid) + CW'(1);
                    end else begin
                        n_hip1 = CW'(mid);
                    end
                end else begin
                    n_pos   = r_lo[IW-1:0];
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (r_action == A_INSERT) begin
                    n_count = r_count + CW'(1);
                end else begin
                    n_count = CW'(r_req);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = M_TDATA_W'({CNT_OUT_W'(r_count), smallest});
                    n_out_rej   = r_rej;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_action   <= n_action;
        r_value    <= n_value;
        r_req      <= n_req;
        r_lo       <= n_lo;
        r_hip1     <= n_hip1;
        r_pos      <= n_pos;
        r_rej      <= n_rej;
        r_out_data <= n_out_data;
        r_out_rej  <= n_out_rej;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_rej;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMPW'(r_count) <= DEPTH_C)
        else $error("entry count above depth");

    a_search_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_lo <= r_hip1) && (r_hip1 <= r_count))
        else $error("search window out of range");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_action == A_INSERT) |=>
            (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not grow count by one");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside done state");
`endif

endmodule
